// ===== src/double_ended_queue_assert.svh =====
// Assertion macros for the double-ended queue RTL.
// Used by files that include this header; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication under an active-low reset.
`define DQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under an active-low reset.
`define DQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dq_pkg.sv =====
// Shared types, constants and index helpers for the double-ended queue.
// No dependencies.
`default_nettype none

package dq_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned DATA_WIDTH  = 32;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned OP_W        = 2;
  localparam int unsigned ST_W        = 2;
  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned CNT_FIELD_W = 5;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  function automatic idx_t idx_next(input idx_t i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

  function automatic idx_t idx_prev(input idx_t i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : idx_t'(i - 1'b1);
  endfunction

endpackage

`default_nettype wire

// ===== src/dq_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/double_ended_queue.sv =====
// Double-ended queue top level: ring storage in dq_ram, head/tail/count control.
// Depends on dq_pkg, dq_ram and double_ended_queue_assert.svh.
//
// A bounded deque of DEPTH words kept in a ring buffer. The front and back words are
// held in registers, so a push needs no RAM read and its transaction is offered
// on the output the cycle after it is accepted. A pop that leaves at least one word
// passes through S_READ: the new end word is fetched through the RAM's registered read
// port. A pop that empties the deque, or a refused push or pop, skips S_READ. One
// operation is in flight at a time; a new one is accepted while a finished result
// is being taken. Storage needs no clearing after reset.
`default_nettype none

`include "double_ended_queue_assert.svh"

module double_ended_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [dq_pkg::OP_W-1:0]         operation_i,
  input  logic [dq_pkg::FIELD_W-1:0]      data_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dq_pkg::ST_W-1:0]         status_o,
  output logic [dq_pkg::FIELD_W-1:0]      popped_value_o,
  output logic [dq_pkg::FIELD_W-1:0]      front_value_o,
  output logic [dq_pkg::FIELD_W-1:0]      back_value_o,
  output logic [dq_pkg::CNT_FIELD_W-1:0]  item_count_o,
  output logic                            is_empty_o
);

  import dq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e  state_q, state_d;
  idx_t    head_q, head_d, tail_q, tail_d;
  cnt_t    count_q, count_d;
  data_t   front_q, front_d, back_q, back_d;
  data_t   popped_q, popped_d;
  status_e status_q, status_d;
  logic    out_valid_q, out_valid_d;
  logic    pop_front_q, pop_front_d;

  logic    ram_we, ram_re;
  idx_t    ram_waddr, ram_raddr;
  data_t   ram_rdata;

  logic    accept, full, empty, single, push_ok;
  op_e     op;
  data_t   word;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign op         = op_e'(operation_i);
  assign word       = DATA_WIDTH'(data_value_i);
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);
  assign single     = (count_q == CNT_W'(1));
  assign push_ok    = accept && !full && (op inside {OP_PUSH_FRONT, OP_PUSH_BACK});

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (word),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    front_d     = front_q;
    back_d      = back_q;
    popped_d    = popped_q;
    status_d    = status_q;
    pop_front_d = pop_front_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = head_q;
    ram_re      = 1'b0;
    ram_raddr   = head_q;

    if (state_q == S_READ) begin
      if (pop_front_q) begin
        front_d = ram_rdata;
      end else begin
        back_d = ram_rdata;
      end
      out_valid_d = 1'b1;
      state_d     = S_IDLE;
    end else if (accept) begin
      popped_d    = '0;
      status_d    = ST_OK;
      out_valid_d = 1'b1;
      case (op)
        OP_PUSH_FRONT: begin
          if (full) begin
            status_d = ST_OVERFLOW;
          end else begin
            head_d    = idx_prev(head_q);
            ram_we    = 1'b1;
            ram_waddr = idx_prev(head_q);
            count_d   = cnt_t'(count_q + 1'b1);
            front_d   = word;
            if (empty) begin
              back_d = word;
            end
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            status_d = ST_OVERFLOW;
          end else begin
            tail_d    = idx_next(tail_q);
            ram_we    = 1'b1;
            ram_waddr = idx_next(tail_q);
            count_d   = cnt_t'(count_q + 1'b1);
            back_d    = word;
            if (empty) begin
              front_d = word;
            end
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status_d = ST_UNDERFLOW;
          end else begin
            popped_d = front_q;
            head_d   = idx_next(head_q);
            count_d  = cnt_t'(count_q - 1'b1);
            if (single) begin
              front_d = '0;
              back_d  = '0;
            end else begin
              ram_re      = 1'b1;
              ram_raddr   = idx_next(head_q);
              pop_front_d = 1'b1;
              out_valid_d = 1'b0;
              state_d     = S_READ;
            end
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            status_d = ST_UNDERFLOW;
          end else begin
            popped_d = back_q;
            tail_d   = idx_prev(tail_q);
            count_d  = cnt_t'(count_q - 1'b1);
            if (single) begin
              front_d = '0;
              back_d  = '0;
            end else begin
              ram_re      = 1'b1;
              ram_raddr   = idx_prev(tail_q);
              pop_front_d = 1'b0;
              out_valid_d = 1'b0;
              state_d     = S_READ;
            end
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= IDX_W'(DEPTH - 1);
      count_q     <= '0;
      front_q     <= '0;
      back_q      <= '0;
      popped_q    <= '0;
      out_valid_q <= 1'b0;
      pop_front_q <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      front_q     <= front_d;
      back_q      <= back_d;
      popped_q    <= popped_d;
      out_valid_q <= out_valid_d;
      pop_front_q <= pop_front_d;
      status_q    <= status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign popped_value_o = FIELD_W'(popped_q);
  assign front_value_o  = FIELD_W'(front_q);
  assign back_value_o   = FIELD_W'(back_q);
  assign item_count_o   = CNT_FIELD_W'(count_q);
  assign is_empty_o     = empty;

  `DQ_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(DEPTH), "count overflow")
  `DQ_ASSERT_IMPL(a_read_no_out, clk_i, rst_ni, state_q == S_READ, !out_valid_q, "read result")
  `DQ_ASSERT_IMPL(a_empty_zero, clk_i, rst_ni, empty, front_q == '0 && back_q == '0, "stale end")
  `DQ_ASSERT_NEXT(a_push_count, clk_i, rst_ni, push_ok, count_q == cnt_t'($past(count_q) + 1'b1), "push count")
  `DQ_ASSERT_NEXT(a_read_done, clk_i, rst_ni, state_q == S_READ, out_valid_q, "read not finished")

endmodule

`default_nettype wire

// ===== verif/double_ended_queue_test.sv =====
// Self-checking testbench for double_ended_queue: directed table, then random traffic.
// Depends on dq_pkg and the double_ended_queue RTL; results checked against fixed table rows or a local deque model.
`default_nettype none

module double_ended_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 500;
  localparam int unsigned RANDOM_ITEMS   = 1200;
  localparam int unsigned TAIL_CYCLES    = 20;

  typedef logic [FIELD_W-1:0]     field_t;
  typedef logic [CNT_FIELD_W-1:0] count_t;

  typedef struct packed {
    status_e status;
    field_t  popped;
    field_t  front;
    field_t  back;
    count_t  count;
    logic    empty;
  } deque_result_t;

  typedef struct {
    op_e           op;
    field_t        word;
    bit            fixed;
    deque_result_t want;
  } table_row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [OP_W-1:0] operation = '0;
  field_t        data_value = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [ST_W-1:0] status;
  field_t        popped_value;
  field_t        front_value;
  field_t        back_value;
  count_t        item_count;
  logic          is_empty;

  double_ended_queue uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (operation),
    .data_value_i   (data_value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .popped_value_o (popped_value),
    .front_value_o  (front_value),
    .back_value_o   (back_value),
    .item_count_o   (item_count),
    .is_empty_o     (is_empty)
  );

  data_t        deque_words [DEPTH];
  int unsigned  model_head  = 0;
  int unsigned  model_count = 0;

  deque_result_t expected_results [$];
  table_row_t    stimulus_table [$];

  int unsigned error_count    = 0;
  int unsigned results_seen   = 0;
  int unsigned pushes_ok      = 0;
  int unsigned pops_ok        = 0;
  int unsigned overflows      = 0;
  int unsigned underflows     = 0;
  int unsigned full_hits      = 0;
  int unsigned empty_hits     = 0;
  int unsigned idle_cycles    = 0;
  bit          tx_burst       = 1'b0;
  bit          rx_burst       = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic deque_result_t predict_deque(op_e op, field_t word);
    deque_result_t r;
    int unsigned   pos;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (model_count >= DEPTH) begin
          r.status = ST_OVERFLOW;
          overflows++;
        end else begin
          if (op == OP_PUSH_FRONT) begin
            model_head = (model_head + DEPTH - 1) % DEPTH;
            pos = model_head;
          end else begin
            pos = (model_head + model_count) % DEPTH;
          end
          deque_words[pos] = data_t'(word);
          model_count++;
          pushes_ok++;
          if (model_count == DEPTH) full_hits++;
        end
      end
      default: begin
        if (model_count == 0) begin
          r.status = ST_UNDERFLOW;
          underflows++;
        end else begin
          if (op == OP_POP_FRONT) begin
            r.popped = field_t'(deque_words[model_head]);
            model_head = (model_head + 1) % DEPTH;
          end else begin
            r.popped = field_t'(deque_words[(model_head + model_count - 1) % DEPTH]);
          end
          model_count--;
          pops_ok++;
          if (model_count == 0) empty_hits++;
        end
      end
    endcase
    if (model_count != 0) begin
      r.front = field_t'(deque_words[model_head]);
      r.back  = field_t'(deque_words[(model_head + model_count - 1) % DEPTH]);
    end
    r.count = count_t'(model_count);
    r.empty = (model_count == 0);
    return r;
  endfunction

  task automatic report_error(string msg);
    error_count++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic compare_field(string name, field_t got, field_t want);
    if (got !== want)
      report_error($sformatf("result %0d: %s is %h, expected %h", results_seen, name, got, want));
  endtask

  task automatic add_row(op_e op, field_t word, bit fixed, status_e st, field_t popped,
                         field_t front, field_t back, int unsigned count);
    table_row_t row;
    row.op          = op;
    row.word        = word;
    row.fixed       = fixed;
    row.want.status = st;
    row.want.popped = popped;
    row.want.front  = front;
    row.want.back   = back;
    row.want.count  = count_t'(count);
    row.want.empty  = (count == 0);
    stimulus_table.push_back(row);
  endtask

  task automatic send_op(op_e op, field_t word, bit fixed, deque_result_t typed);
    int unsigned   gap;
    deque_result_t predicted;
    gap = tx_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    data_value <= word;
    do @(negedge clk_i); while (!in_ready);
    @(posedge clk_i);
    predicted = predict_deque(op, word);
    expected_results.push_back(fixed ? typed : predicted);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  function automatic field_t random_word();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      2:       return field_t'(1) << $urandom_range(0, FIELD_W - 1);
      3:       return ~(field_t'(1) << $urandom_range(0, FIELD_W - 1));
      default: return field_t'($urandom);
    endcase
  endfunction

  // Watchdog: sampled at the falling edge, when handshakes have settled.
  always @(negedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : receiver
    int unsigned   gap;
    deque_result_t want;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = rx_burst ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(negedge clk_i); while (!out_valid);
      results_seen++;
      if (expected_results.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_results.pop_front();
        compare_field("status", field_t'(status), field_t'(want.status));
        compare_field("popped_value", popped_value, want.popped);
        compare_field("front_value", front_value, want.front);
        compare_field("back_value", back_value, want.back);
        compare_field("item_count", field_t'(item_count), field_t'(want.count));
        compare_field("is_empty", field_t'(is_empty), field_t'(want.empty));
      end
      @(posedge clk_i);
    end
  end

  initial begin : sender
    int unsigned seg_len;
    int unsigned push_pct;
    int unsigned sent;
    bit          first_seg;
    op_e         op;

    add_row(OP_POP_FRONT, '0, 1, ST_UNDERFLOW, '0, '0, '0, 0);
    add_row(OP_POP_BACK, '1, 1, ST_UNDERFLOW, '0, '0, '0, 0);
    add_row(OP_PUSH_FRONT, '1, 1, ST_OK, '0, '1, '1, 1);
    add_row(OP_PUSH_BACK, '0, 1, ST_OK, '0, '1, '0, 2);
    add_row(OP_POP_BACK, 32'h1234_5678, 1, ST_OK, '0, '1, '1, 1);
    add_row(OP_POP_FRONT, '0, 1, ST_OK, '1, '0, '0, 0);
    for (int k = 0; k < 8; k++) begin
      add_row(OP_PUSH_FRONT, field_t'(1) << k, 0, ST_OK, '0, '0, '0, 0);
      add_row(OP_PUSH_BACK, field_t'(1) << (k + 16), 0, ST_OK, '0, '0, '0, 0);
    end
    add_row(OP_PUSH_FRONT, 32'hDEAD_BEEF, 1, ST_OVERFLOW, '0, 32'h0000_0080, 32'h0080_0000, 16);
    add_row(OP_PUSH_BACK, 32'hDEAD_BEEF, 1, ST_OVERFLOW, '0, 32'h0000_0080, 32'h0080_0000, 16);
    add_row(OP_POP_FRONT, '0, 1, ST_OK, 32'h0000_0080, 32'h0000_0040, 32'h0080_0000, 15);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (stimulus_table[i])
      send_op(stimulus_table[i].op, stimulus_table[i].word, stimulus_table[i].fixed,
              stimulus_table[i].want);

    sent      = 0;
    first_seg = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      seg_len = $urandom_range(20, 80);
      case ($urandom_range(0, 4))
        0:       push_pct = 5;
        1:       push_pct = 30;
        2:       push_pct = 50;
        3:       push_pct = 70;
        default: push_pct = 95;
      endcase
      if (first_seg || $urandom_range(0, 2) == 0) drain_results();
      tx_burst  = ($urandom_range(0, 3) == 0);
      rx_burst  = ($urandom_range(0, 3) == 0);
      first_seg = 1'b0;
      for (int n = 0; n < seg_len && sent < RANDOM_ITEMS; n++) begin
        if ($urandom_range(0, 99) < push_pct)
          op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        else
          op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        send_op(op, random_word(), 0, '0);
        sent++;
      end
    end

    in_valid <= 1'b0;
    rx_burst = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_error($sformatf("%0d expected results never arrived", expected_results.size()));

    $display("Covered %0d directed and %0d random transactions, %0d results checked",
             stimulus_table.size(), sent, results_seen);
    $display("Pushes %0d, pops %0d, overflows %0d, underflows %0d, full %0d times, empty %0d times",
             pushes_ok, pops_ok, overflows, underflows, full_hits, empty_hits);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
